### src/scfc_pkg.sv
// package for the stream credit flow controller
// holds widths, opcode and class codes, queue and result types, saturating helpers
// no dependencies
`default_nettype none

package scfc_pkg;

  localparam int unsigned VAL_W        = 62;
  localparam int unsigned OP_W         = 4;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned STREAM_SLOTS = 16;
  localparam int unsigned SLOT_W       = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t MAXV           = '1;
  localparam val_t DEFAULT_WINDOW = val_t'(65536);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONN_WINDOW   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_WINDOW = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_PEER_MAX_DATA   = 4'd0,
    OP_PEER_STREAM_MAX = 4'd1,
    OP_OPEN            = 4'd2,
    OP_SENT            = 4'd3,
    OP_RECEIVED        = 4'd4,
    OP_CONSUMED        = 4'd5,
    OP_CLOSE           = 4'd6,
    OP_ISSUE_CONN      = 4'd7,
    OP_ISSUE_STREAM    = 4'd8
  } opcode_e;

  // event class handed from the front to the back
  typedef enum logic [3:0] {
    K_NOP,
    K_CONN_LIMIT,
    K_STREAM_LIMIT,
    K_OPEN,
    K_SENT,
    K_RECV,
    K_CONSUME,
    K_CLOSE,
    K_ISSUE_CONN,
    K_ISSUE_STREAM
  } kind_e;

  typedef enum logic [1:0] {
    B_LOOKUP,
    B_EXEC,
    B_REPORT
  } bstate_e;

  // amount carries the receive end offset for received events
  typedef struct packed {
    kind_e kind;
    val_t  stream_number;
    val_t  amount;
  } entry_t;

  typedef struct packed {
    logic conn_blocked;
    val_t conn_send_window;
    logic stream_present;
    logic stream_blocked;
    val_t stream_send_window;
    logic conn_update_due;
    logic stream_update_due;
    logic issued;
    val_t issued_limit;
    logic table_full;
  } result_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? MAXV : s[VAL_W-1:0];
  endfunction

  function automatic val_t send_window(val_t limit, val_t sent);
    return (limit > sent) ? (limit - sent) : '0;
  endfunction

  // remaining credit below half the window
  function automatic logic update_due(val_t consumed, val_t granted, val_t window);
    val_t           rem;
    logic [VAL_W:0] twice;
    rem   = granted - consumed;
    twice = {rem, 1'b0};
    if (consumed >= granted) begin
      return 1'b1;
    end
    return twice < {1'b0, window};
  endfunction

endpackage

`default_nettype wire

### src/scfc_if.sv
// channel interfaces for the stream credit flow controller
// event input, configuration write and result output; uses scfc_pkg widths
`default_nettype none

interface scfc_in_if;
  logic                         valid;
  logic                         ready;
  logic [scfc_pkg::OP_W-1:0]    opcode;
  logic [scfc_pkg::VAL_W-1:0]   stream_number;
  logic [scfc_pkg::VAL_W-1:0]   amount;
  logic [scfc_pkg::LEN_W-1:0]   frame_length;
  modport source (output valid, opcode, stream_number, amount, frame_length, input ready);
  modport sink   (input valid, opcode, stream_number, amount, frame_length, output ready);
endinterface

interface scfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scfc_pkg::CFG_IDX_W-1:0]  index;
  logic [scfc_pkg::VAL_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface scfc_res_if;
  logic                        valid;
  logic                        ready;
  logic                        conn_blocked;
  logic [scfc_pkg::VAL_W-1:0]  conn_send_window;
  logic                        stream_present;
  logic                        stream_blocked;
  logic [scfc_pkg::VAL_W-1:0]  stream_send_window;
  logic                        conn_update_due;
  logic                        stream_update_due;
  logic                        issued;
  logic [scfc_pkg::VAL_W-1:0]  issued_limit;
  logic                        table_full;
  modport source (output valid, conn_blocked, conn_send_window, stream_present,
                  stream_blocked, stream_send_window, conn_update_due,
                  stream_update_due, issued, issued_limit, table_full, input ready);
  modport sink   (input valid, conn_blocked, conn_send_window, stream_present,
                  stream_blocked, stream_send_window, conn_update_due,
                  stream_update_due, issued, issued_limit, table_full, output ready);
endinterface

`default_nettype wire

### src/scfc_front.sv
// front end: accepts event transactions, classifies them and queues them
// depends on scfc_pkg and scfc_in_if
`default_nettype none

module scfc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  scfc_in_if.sink          in_i,
  output logic             q_valid_o,
  output scfc_pkg::entry_t q_head_o,
  input  logic             q_pop_i
);
  import scfc_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  entry_t            entry_d;

  assign in_i.ready = (cnt_q != QCNT_W'(QDEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign q_head_o   = mem_q[rd_ptr_q];

  // classify the opcode, fold the received frame into its end offset
  always_comb begin
    entry_d.stream_number = in_i.stream_number;
    entry_d.amount        = in_i.amount;
    case (opcode_e'(in_i.opcode))
      OP_PEER_MAX_DATA:   entry_d.kind = K_CONN_LIMIT;
      OP_PEER_STREAM_MAX: entry_d.kind = K_STREAM_LIMIT;
      OP_OPEN:            entry_d.kind = K_OPEN;
      OP_SENT:            entry_d.kind = K_SENT;
      OP_RECEIVED: begin
        entry_d.kind   = K_RECV;
        entry_d.amount = sat_add(in_i.amount, VAL_W'(in_i.frame_length));
      end
      OP_CONSUMED:        entry_d.kind = K_CONSUME;
      OP_CLOSE:           entry_d.kind = K_CLOSE;
      OP_ISSUE_CONN:      entry_d.kind = K_ISSUE_CONN;
      OP_ISSUE_STREAM:    entry_d.kind = K_ISSUE_STREAM;
      default:            entry_d.kind = K_NOP;
    endcase
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/scfc_back.sv
// back end: stream table lookup, credit update and result register
// depends on scfc_pkg, scfc_cfg_if and scfc_res_if
`default_nettype none

module scfc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  scfc_pkg::entry_t q_head_i,
  output logic             q_pop_o,
  scfc_cfg_if.sink         cfg_i,
  scfc_res_if.source       res_o
);
  import scfc_pkg::*;

  // configuration and connection counters
  val_t conn_window_q, stream_window_q;
  val_t conn_sent_q, conn_limit_q, conn_recv_q, conn_cons_q, conn_grant_q;
  val_t conn_sent_d, conn_limit_d, conn_recv_d, conn_cons_d, conn_grant_d;

  // stream table
  logic slot_valid_q [STREAM_SLOTS];
  val_t slot_id_q    [STREAM_SLOTS];
  val_t slot_sent_q  [STREAM_SLOTS];
  val_t slot_limit_q [STREAM_SLOTS];
  val_t slot_mark_q  [STREAM_SLOTS];
  val_t slot_cons_q  [STREAM_SLOTS];
  val_t slot_grant_q [STREAM_SLOTS];

  bstate_e           state_q, state_d;
  logic [SLOT_W-1:0] tgt_q;
  logic              hit_q, create_q, full_q, present_q, issued_q, out_valid_q;
  val_t              issued_lim_q;
  result_t           res_q, rep;

  logic [STREAM_SLOTS-1:0] match;
  logic              hit, free_found, needs_slot;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic              look_en, exec_en, load_out, cfg_wr;

  val_t cur_sent, cur_limit, cur_mark, cur_cons, cur_grant, mark_eff, nl_s, nl_c;
  val_t s_sent_d, s_limit_d, s_mark_d, s_cons_d, s_grant_d;
  logic s_write, s_valid_clr, issued_d;
  val_t issued_lim_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  // associative match and lowest free slot
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < STREAM_SLOTS; i++) begin
      match[i] = slot_valid_q[i] && (slot_id_q[i] == q_head_i.stream_number);
    end
    for (int i = STREAM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign needs_slot = (q_head_i.kind == K_STREAM_LIMIT) || (q_head_i.kind == K_OPEN) ||
                      (q_head_i.kind == K_RECV);

  // next state
  always_comb begin
    case (state_q)
      B_LOOKUP: state_d = q_valid_i ? B_EXEC : B_LOOKUP;
      B_EXEC:   state_d = B_REPORT;
      B_REPORT: state_d = (!out_valid_q || res_o.ready) ? B_LOOKUP : B_REPORT;
      default:  state_d = B_LOOKUP;
    endcase
  end

  // sequencer outputs
  always_comb begin
    look_en  = 1'b0;
    exec_en  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_LOOKUP: look_en  = q_valid_i;
      B_EXEC:   exec_en  = 1'b1;
      B_REPORT: load_out = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  assign q_pop_o = exec_en;

  assign cur_sent  = slot_sent_q[tgt_q];
  assign cur_limit = slot_limit_q[tgt_q];
  assign cur_mark  = slot_mark_q[tgt_q];
  assign cur_cons  = slot_cons_q[tgt_q];
  assign cur_grant = slot_grant_q[tgt_q];

  // credit update for the queued event
  always_comb begin
    conn_sent_d  = conn_sent_q;
    conn_limit_d = conn_limit_q;
    conn_recv_d  = conn_recv_q;
    conn_cons_d  = conn_cons_q;
    conn_grant_d = conn_grant_q;
    s_sent_d     = cur_sent;
    s_limit_d    = cur_limit;
    s_mark_d     = cur_mark;
    s_cons_d     = cur_cons;
    s_grant_d    = cur_grant;
    s_write      = 1'b0;
    s_valid_clr  = 1'b0;
    issued_d     = 1'b0;
    issued_lim_d = '0;
    mark_eff     = create_q ? '0 : cur_mark;
    nl_s         = '0;
    nl_c         = '0;
    // fresh entry
    if (create_q) begin
      s_sent_d  = '0;
      s_limit_d = (q_head_i.kind == K_RECV) ? '0 : q_head_i.amount;
      s_mark_d  = '0;
      s_cons_d  = '0;
      s_grant_d = stream_window_q;
      s_write   = 1'b1;
    end
    case (q_head_i.kind)
      K_CONN_LIMIT: begin
        if (q_head_i.amount > conn_limit_q) conn_limit_d = q_head_i.amount;
      end
      K_STREAM_LIMIT: begin
        if (hit_q && (q_head_i.amount > cur_limit)) begin
          s_limit_d = q_head_i.amount;
          s_write   = 1'b1;
        end
      end
      K_SENT: begin
        conn_sent_d = sat_add(conn_sent_q, q_head_i.amount);
        if (hit_q) begin
          s_sent_d = sat_add(cur_sent, q_head_i.amount);
          s_write  = 1'b1;
        end
      end
      K_RECV: begin
        if ((hit_q || create_q) && (q_head_i.amount > mark_eff)) begin
          conn_recv_d = sat_add(conn_recv_q, q_head_i.amount - mark_eff);
          s_mark_d    = q_head_i.amount;
          s_write     = 1'b1;
        end
      end
      K_CONSUME: begin
        if (hit_q) begin
          nl_s        = sat_add(cur_cons, q_head_i.amount);
          nl_c        = sat_add(conn_cons_q, q_head_i.amount);
          s_cons_d    = (nl_s > cur_mark) ? cur_mark : nl_s;
          conn_cons_d = (nl_c > conn_recv_q) ? conn_recv_q : nl_c;
          s_write     = 1'b1;
        end
      end
      K_CLOSE: begin
        s_valid_clr = hit_q;
      end
      K_ISSUE_CONN: begin
        nl_c = sat_add(conn_cons_q, conn_window_q);
        if (nl_c > conn_grant_q) begin
          conn_grant_d = nl_c;
          issued_d     = 1'b1;
          issued_lim_d = nl_c;
        end
      end
      K_ISSUE_STREAM: begin
        nl_s = sat_add(cur_cons, stream_window_q);
        if (hit_q && (nl_s > cur_grant)) begin
          s_grant_d    = nl_s;
          s_write      = 1'b1;
          issued_d     = 1'b1;
          issued_lim_d = nl_s;
        end
      end
      default: ;
    endcase
  end

  // status of the connection and the named stream
  always_comb begin
    rep.conn_blocked       = conn_sent_q >= conn_limit_q;
    rep.conn_send_window   = send_window(conn_limit_q, conn_sent_q);
    rep.stream_present     = present_q;
    rep.stream_blocked     = !present_q || (cur_sent >= cur_limit);
    rep.stream_send_window = present_q ? send_window(cur_limit, cur_sent) : '0;
    rep.conn_update_due    = update_due(conn_cons_q, conn_grant_q, conn_window_q);
    rep.stream_update_due  = present_q && update_due(cur_cons, cur_grant, stream_window_q);
    rep.issued             = issued_q;
    rep.issued_limit       = issued_lim_q;
    rep.table_full         = full_q;
  end

  // stream table payload
  always_ff @(posedge clk_i) begin
    if (exec_en && s_write) begin
      slot_sent_q[tgt_q]  <= s_sent_d;
      slot_limit_q[tgt_q] <= s_limit_d;
      slot_mark_q[tgt_q]  <= s_mark_d;
      slot_cons_q[tgt_q]  <= s_cons_d;
      slot_grant_q[tgt_q] <= s_grant_d;
    end
    if (exec_en && create_q) begin
      slot_id_q[tgt_q] <= q_head_i.stream_number;
    end
  end

  // slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STREAM_SLOTS; i++) slot_valid_q[i] <= 1'b0;
    end else if (exec_en) begin
      if (create_q) slot_valid_q[tgt_q] <= 1'b1;
      else if (s_valid_clr) slot_valid_q[tgt_q] <= 1'b0;
    end
  end

  // configuration and connection counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_window_q   <= DEFAULT_WINDOW;
      stream_window_q <= DEFAULT_WINDOW;
      conn_sent_q     <= '0;
      conn_limit_q    <= '0;
      conn_recv_q     <= '0;
      conn_cons_q     <= '0;
      conn_grant_q    <= DEFAULT_WINDOW;
    end else begin
      if (exec_en) begin
        conn_sent_q  <= conn_sent_d;
        conn_limit_q <= conn_limit_d;
        conn_recv_q  <= conn_recv_d;
        conn_cons_q  <= conn_cons_d;
      end
      // a connection window write also sets the granted limit
      if (cfg_wr && (cfg_i.index == CFG_CONN_WINDOW)) begin
        conn_window_q <= cfg_i.data;
        conn_grant_q  <= cfg_i.data;
      end else if (exec_en) begin
        conn_grant_q <= conn_grant_d;
      end
      if (cfg_wr && (cfg_i.index == CFG_STREAM_WINDOW)) begin
        stream_window_q <= cfg_i.data;
      end
    end
  end

  // sequencer and per-transaction flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_LOOKUP;
      tgt_q        <= '0;
      hit_q        <= 1'b0;
      create_q     <= 1'b0;
      full_q       <= 1'b0;
      present_q    <= 1'b0;
      issued_q     <= 1'b0;
      issued_lim_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (look_en) begin
        tgt_q    <= hit ? hit_idx : free_idx;
        hit_q    <= hit;
        create_q <= needs_slot && !hit && free_found;
        full_q   <= needs_slot && !hit && !free_found;
      end
      if (exec_en) begin
        present_q    <= (hit_q || create_q) && (q_head_i.kind != K_CLOSE);
        issued_q     <= issued_d;
        issued_lim_q <= issued_lim_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= rep;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.conn_blocked       = res_q.conn_blocked;
  assign res_o.conn_send_window   = res_q.conn_send_window;
  assign res_o.stream_present     = res_q.stream_present;
  assign res_o.stream_blocked     = res_q.stream_blocked;
  assign res_o.stream_send_window = res_q.stream_send_window;
  assign res_o.conn_update_due    = res_q.conn_update_due;
  assign res_o.stream_update_due  = res_q.stream_update_due;
  assign res_o.issued             = res_q.issued;
  assign res_o.issued_limit       = res_q.issued_limit;
  assign res_o.table_full         = res_q.table_full;

  // at most one slot holds a given stream number
  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> $onehot0(match)) else $error("stream number held by more than one slot");

  // a full table never leaves the stream present
  a_full_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_REPORT) && full_q |-> !present_q)
    else $error("table full but stream reported present");

  // a new entry is only made when the stream was not found
  a_create_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    create_q |-> !hit_q) else $error("entry created for a present stream");

  // an issued limit is always above zero
  a_issued_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.issued |-> (res_o.issued_limit != '0))
    else $error("issued limit of zero");

  // an event leaves the queue only after a lookup
  a_pop_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> $past(state_q) == B_LOOKUP) else $error("pop without lookup");

endmodule

`default_nettype wire

### src/stream_credit_flow_controller.sv
// stream credit flow controller: connection and per-stream credit counters
// with a 16-entry associative stream table.
// channels: in_i carries one event transaction (opcode, stream_number, amount,
// frame_length); res_o returns exactly one status transaction per event;
// cfg_i writes conn_window (index 0, also resets the granted limit) and
// stream_window (index 1); the user must write them only while the block is
// idle; the block itself does not enforce it. The back end works one event
// at a time: table lookup, credit update, then status load into the result
// register, a sequence set around the single read-modify-write port of the
// stream table.
// a two-entry queue lets the front accept events while the back is busy.
// reset: counters clear, granted limit and both windows return to 65536,
// every table slot becomes free; no clearing pass is needed.
// when the receiver stalls the result holds, the back end waits in its report
// step and the front keeps accepting until the queue is full.
// depends on scfc_pkg, scfc_if, scfc_front and scfc_back
`default_nettype none

module stream_credit_flow_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  scfc_in_if.sink    in_i,
  scfc_cfg_if.sink   cfg_i,
  scfc_res_if.source res_o
);
  import scfc_pkg::*;

  logic   q_valid, q_pop;
  entry_t q_head;

  // event classification and queue
  scfc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_head_o  (q_head),
    .q_pop_i   (q_pop)
  );

  // table lookup, credit update and result
  scfc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg_i),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
